// ===== rtl/sawq_pkg.sv =====
// Shared types, constants and command/status structs of the slot allocator.
package sawq_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int WAIT_DEPTH_DEF = 32;
  localparam int ID_W           = 17;
  localparam int CFG_W          = 5;
  localparam int SLOT_OUT_W     = 4;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_QFULL     = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_WITHDRAWN = 3'd5,
    ST_NOTFOUND  = 3'd6
  } status_t;

  typedef enum logic {
    MODE_ARRIVE = 1'b0,
    MODE_DEPART = 1'b1
  } mode_t;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] requester_id;
  } request_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [ID_W-1:0]       result_id;
    logic                  last;
  } result_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ALLOC,
    ACT_PROMOTE,
    ACT_PUSH,
    ACT_RELEASE,
    ACT_WITHDRAW
  } action_t;

  typedef struct packed {
    logic    latch;
    logic    scan;
    action_t action;
    logic    emit;
    status_t status;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic owner_found;
    logic wait_found;
    logic free_found;
    logic q_empty;
    logic q_full;
  } sts_t;

endpackage

// ===== rtl/sawq_datapath.sv =====
// Datapath: slot table, wait queue, match/search vectors and result register.
module sawq_datapath
  import sawq_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  request_t         request,
  input  cmd_t             cmd,
  output sts_t             sts,
  output result_t          result
);

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WIW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WCW = $clog2(WAIT_DEPTH + 1);

  logic [CFG_W-1:0] active_slots;
  logic [SLOTS-1:0] slot_busy;
  logic [ID_W-1:0]  slot_owner [SLOTS];
  logic [ID_W-1:0]  wait_entries [WAIT_DEPTH];
  logic [WCW-1:0]   wait_count;
  request_t         req;
  result_t          res;

  logic [SLOTS-1:0]      owner_hit, owner_hit_q;
  logic [SLOTS-1:0]      free_vec, free_vec_q;
  logic [WAIT_DEPTH-1:0] wait_hit, wait_hit_q;

  logic [SIW-1:0] owner_pos, free_pos;
  logic [WIW-1:0] wait_pos, rm_pos;
  logic [SIW+SLOT_OUT_W-1:0] slot_ext;
  logic [ID_W-1:0] emit_id;

  // Parallel match against the latched ID
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    assign owner_hit[i] = slot_busy[i] && (int'(active_slots) > i) &&
                          (slot_owner[i] == req.requester_id);
    assign free_vec[i]  = !slot_busy[i] && (int'(active_slots) > i);
  end

  for (genvar j = 0; j < WAIT_DEPTH; j++) begin : g_wait
    assign wait_hit[j] = (WCW'(j) < wait_count) &&
                         (wait_entries[j] == req.requester_id);
  end

  // Lowest-index pick from the registered vectors
  always_comb begin
    owner_pos = '0;
    free_pos  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (owner_hit_q[i]) owner_pos = SIW'(i);
      if (free_vec_q[i])  free_pos  = SIW'(i);
    end
  end

  always_comb begin
    wait_pos = '0;
    for (int j = WAIT_DEPTH - 1; j >= 0; j--) begin
      if (wait_hit_q[j]) wait_pos = WIW'(j);
    end
  end

  assign rm_pos = (cmd.action == ACT_PROMOTE) ? '0 : wait_pos;

  always_comb begin
    case (cmd.action)
      ACT_ALLOC, ACT_PROMOTE: slot_ext = {{SLOT_OUT_W{1'b0}}, free_pos};
      ACT_RELEASE:            slot_ext = {{SLOT_OUT_W{1'b0}}, owner_pos};
      default:                slot_ext = '0;
    endcase
  end

  assign emit_id = (cmd.action == ACT_PROMOTE) ? wait_entries[0] : req.requester_id;

  assign sts.mode        = req.mode;
  assign sts.owner_found = |owner_hit_q;
  assign sts.wait_found  = |wait_hit_q;
  assign sts.free_found  = |free_vec_q;
  assign sts.q_empty     = (wait_count == '0);
  assign sts.q_full      = (wait_count == WCW'(WAIT_DEPTH));

  assign result = res;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACTIVE_RESET;
      slot_busy    <= '0;
      wait_count   <= '0;
    end else begin
      if (cfg_we) active_slots <= cfg_data;
      case (cmd.action)
        ACT_ALLOC: slot_busy[free_pos] <= 1'b1;
        ACT_PROMOTE: begin
          slot_busy[free_pos] <= 1'b1;
          wait_count          <= wait_count - 1'b1;
        end
        ACT_PUSH:     wait_count <= wait_count + 1'b1;
        ACT_RELEASE:  slot_busy[owner_pos] <= 1'b0;
        ACT_WITHDRAW: wait_count <= wait_count - 1'b1;
        default: ;
      endcase
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (cmd.latch) req <= request;
    if (cmd.scan) begin
      owner_hit_q <= owner_hit;
      free_vec_q  <= free_vec;
      wait_hit_q  <= wait_hit;
    end
    if (cmd.action == ACT_ALLOC || cmd.action == ACT_PROMOTE) begin
      slot_owner[free_pos] <= emit_id;
    end
    // close the gap left by a pop or a withdrawal
    for (int j = 0; j < WAIT_DEPTH - 1; j++) begin
      if ((cmd.action == ACT_PROMOTE || cmd.action == ACT_WITHDRAW) &&
          WIW'(j) >= rm_pos) begin
        wait_entries[j] <= wait_entries[j+1];
      end
    end
    for (int j = 0; j < WAIT_DEPTH; j++) begin
      if (cmd.action == ACT_PUSH && wait_count == WCW'(j)) begin
        wait_entries[j] <= req.requester_id;
      end
    end
    if (cmd.emit) begin
      res.status     <= cmd.status;
      res.slot_index <= slot_ext[SLOT_OUT_W-1:0];
      res.result_id  <= emit_id;
      res.last       <= cmd.last;
    end
  end

endmodule

// ===== rtl/sawq_ctrl.sv =====
// Controller: sequences latch, scan and decision steps of each request.
module sawq_ctrl
  import sawq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output logic result_valid,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t state, state_next;
  logic   second;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.action = ACT_NONE;
    cmd.status = ST_ALLOCATED;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.latch = start;
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        if (sts.mode == MODE_ARRIVE) begin
          if (!second && (sts.owner_found || sts.wait_found)) begin
            cmd.status = ST_DUPLICATE;
          end else if (!second && !sts.q_empty && sts.free_found) begin
            // head of queue goes first, then rescan for the newcomer
            cmd.action = ACT_PROMOTE;
            cmd.status = ST_ALLOCATED;
            cmd.last   = 1'b0;
          end else if (sts.q_empty && sts.free_found) begin
            cmd.action = ACT_ALLOC;
            cmd.status = ST_ALLOCATED;
          end else if (!sts.q_full) begin
            cmd.action = ACT_PUSH;
            cmd.status = ST_QUEUED;
          end else begin
            cmd.status = ST_QFULL;
          end
        end else begin
          if (second) begin
            cmd.action = ACT_PROMOTE;
            cmd.status = ST_ALLOCATED;
          end else if (sts.owner_found) begin
            cmd.action = ACT_RELEASE;
            cmd.status = ST_RELEASED;
            cmd.last   = sts.q_empty;
          end else if (sts.wait_found) begin
            cmd.action = ACT_WITHDRAW;
            cmd.status = ST_WITHDRAWN;
          end else begin
            cmd.status = ST_NOTFOUND;
          end
        end
        state_next = cmd.last ? S_IDLE : S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      second       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= cmd.emit;
      if (state == S_IDLE) begin
        second <= 1'b0;
      end else if (cmd.emit && !cmd.last) begin
        second <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/slot_allocator_with_wait_queue.sv =====
// Top level of the slot allocator with FIFO wait queue.
//
// Keeps a pool of SLOTS slots, each free or held by a requester ID, and a
// first-in first-out wait queue of up to WAIT_DEPTH IDs. A request is taken
// at a clock edge where start is high and busy is low. An arrive request is
// rejected as a duplicate if the ID already holds a slot or waits; otherwise
// it takes the lowest free slot, or joins the queue (queue full gives its own
// status). A depart request frees the ID's slot and then moves the queue head
// into the lowest free slot, or withdraws a waiting ID and closes the gap; an
// unknown ID reports not-found. Each request gives one or two results. Each
// result sits on the result port for exactly one cycle, marked by
// result_valid, and must be taken then: there is no way to hold it off.
// The final result of a request has last set.
// Sequence: a request keeps busy high after acceptance through its steps (latch
// and match, then decide); a request that also promotes a waiter matches and
// decides again, since the slot and queue match vectors are rebuilt after the promotion.
// The next request can be accepted in the cycle its last result is shown.
// active_slots (reset 16) limits the usable slots to 0 .. active_slots-1;
// values above SLOTS act as SLOTS and 0 makes every arrival queue. Write it
// only while busy is low and no result is pending.
module slot_allocator_with_wait_queue
  import sawq_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             start,
  input  request_t         request,
  output logic             busy,
  output logic             result_valid,
  output result_t          result
);

  cmd_t cmd;
  sts_t sts;

  // sequencing of each request
  sawq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sts          (sts),
    .busy         (busy),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  // slot table, wait queue and result register
  sawq_datapath #(
    .SLOTS      (SLOTS),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .request  (request),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result)
  );

endmodule
